// File: rtl/skf_pkg.sv
// Shared types, constants and command codes of the scalar Kalman filter.
`timescale 1ns / 1ps
package skf_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int VAR_W           = 48;
  localparam int GAIN_FRAC_BITS  = 24;
  localparam int GAIN_W          = GAIN_FRAC_BITS + 1;
  localparam int DEN_W           = VAR_W + 1;
  localparam int MAG_W           = SAMPLE_W + 1;
  localparam int CHUNK_W         = VAR_W / 2;
  localparam int PROD_W          = GAIN_W + CHUNK_W;
  localparam int CNT_W           = $clog2(GAIN_FRAC_BITS + 1);
  localparam int CFG_IDX_W       = 3;

  localparam logic [GAIN_W-1:0]   GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [PROD_W:0]     GAIN_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [VAR_W-1:0]    VAR_MAX   = {VAR_W{1'b1}};
  localparam logic [CNT_W-1:0]    DIV_LAST  = CNT_W'(GAIN_FRAC_BITS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_UNCERTAINTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE    = 3'd3;

  localparam logic [VAR_W-1:0]           PROCESS_NOISE_RST       = 48'd429497;
  localparam logic [VAR_W-1:0]           MEASUREMENT_NOISE_RST   = 48'd42949673;
  localparam logic [VAR_W-1:0]           INITIAL_UNCERTAINTY_RST = 48'd42949672960000;
  localparam logic signed [SAMPLE_W-1:0] INITIAL_ESTIMATE_RST    = 32'sd655360;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] measurement;
    logic                       first_sample;
  } meas_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] estimate;
    logic [GAIN_W-1:0]          gain;
    logic [VAR_W-1:0]           uncertainty;
  } res_t;

  typedef struct packed {
    logic [VAR_W-1:0]           process_noise;
    logic [VAR_W-1:0]           measurement_noise;
    logic [VAR_W-1:0]           initial_uncertainty;
    logic signed [SAMPLE_W-1:0] initial_estimate;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_LOAD,
    DP_DIV,
    DP_MUL_EL,
    DP_MUL_EH,
    DP_MUL_VL,
    DP_MUL_VH,
    DP_SUM,
    DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_first;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EL,
    ST_EH,
    ST_VL,
    ST_VH,
    ST_SUM,
    ST_FIN
  } state_t;

endpackage

// File: rtl/skf_cfg.sv
// Configuration register file of the scalar Kalman filter.
`timescale 1ns / 1ps
module skf_cfg import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAR_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_noise       <= PROCESS_NOISE_RST;
      cfg.measurement_noise   <= MEASUREMENT_NOISE_RST;
      cfg.initial_uncertainty <= INITIAL_UNCERTAINTY_RST;
      cfg.initial_estimate    <= INITIAL_ESTIMATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROCESS_NOISE:       cfg.process_noise       <= cfg_data;
        REG_MEASUREMENT_NOISE:   cfg.measurement_noise   <= cfg_data;
        REG_INITIAL_UNCERTAINTY: cfg.initial_uncertainty <= cfg_data;
        REG_INITIAL_ESTIMATE:    cfg.initial_estimate    <= signed'(cfg_data[SAMPLE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/skf_ctrl.sv
// Sequencing state machine of the scalar Kalman filter.
`timescale 1ns / 1ps
module skf_ctrl import skf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    meas_valid,
  output logic    meas_stall,
  output logic    res_valid,
  input  logic    res_stall,
  output dp_cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             res_valid_next;
  logic             out_free;

  assign out_free   = !res_valid || !res_stall;
  assign meas_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    res_valid_next = res_valid && res_stall;
    cmd.op         = DP_NOP;
    cmd.div_first  = (cnt == '0);
    case (state)
      ST_IDLE: begin
        if (meas_valid) begin
          cmd.op     = DP_ACCEPT;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op     = DP_LOAD;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle, the integer bit first.
        cmd.op   = DP_DIV;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          state_next = ST_EL;
        end
      end
      ST_EL: begin
        cmd.op     = DP_MUL_EL;
        state_next = ST_EH;
      end
      ST_EH: begin
        cmd.op     = DP_MUL_EH;
        state_next = ST_VL;
      end
      ST_VL: begin
        cmd.op     = DP_MUL_VL;
        state_next = ST_VH;
      end
      ST_VH: begin
        cmd.op     = DP_MUL_VH;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = DP_SUM;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.op         = DP_FIN;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/skf_dp.sv
// Datapath of the scalar Kalman filter: state, serial divider and shared multiplier.
`timescale 1ns / 1ps
module skf_dp import skf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  input  meas_t   meas,
  input  cfg_t    cfg,
  output res_t    res
);

  logic signed [SAMPLE_W-1:0] z;
  logic signed [SAMPLE_W-1:0] x;
  logic [VAR_W-1:0]           p;
  logic [DEN_W-1:0]           den;
  logic                       den_zero;
  logic [DEN_W-1:0]           rem;
  logic [GAIN_W-1:0]          quo;
  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [GAIN_W:0]            acc_e;
  logic [MAG_W-1:0]           delta;
  logic [GAIN_W-1:0]          acc_v;
  logic [PROD_W-1:0]          sum_v;
  logic signed [SAMPLE_W-1:0] est_new;

  logic [GAIN_W-1:0]          g_use;
  logic [GAIN_W-1:0]          mul_a;
  logic [CHUNK_W-1:0]         mul_b;
  logic [DEN_W:0]             shifted;
  logic                       fits;
  logic signed [MAG_W-1:0]    innov;
  logic signed [MAG_W:0]      nx;
  logic [PROD_W:0]            np;
  logic [VAR_W-1:0]           np_sat;
  logic [PROD_W:0]            round_sum;

  // A zero total variance gives a zero gain, which leaves the estimate unchanged.
  assign g_use = den_zero ? '0 : quo;

  assign shifted = cmd.div_first ? {1'b0, rem} : {rem, 1'b0};
  assign fits    = (shifted >= {1'b0, den});
  assign innov   = MAG_W'(z) - MAG_W'(x);

  always_comb begin
    mul_a = g_use;
    mul_b = mag[CHUNK_W-1:0];
    case (cmd.op)
      DP_MUL_EH: mul_b = CHUNK_W'(mag[MAG_W-1:CHUNK_W]);
      DP_MUL_VL: begin
        mul_a = GAIN_ONE - g_use;
        mul_b = p[CHUNK_W-1:0];
      end
      DP_MUL_VH: begin
        mul_a = GAIN_ONE - g_use;
        mul_b = p[VAR_W-1:CHUNK_W];
      end
      default: begin
      end
    endcase
  end

  assign round_sum = {1'b0, prod} + GAIN_HALF;

  always_comb begin
    if (neg) begin
      nx = (MAG_W + 1)'(x) - signed'({1'b0, delta});
    end else begin
      nx = (MAG_W + 1)'(x) + signed'({1'b0, delta});
    end
  end

  assign np     = {1'b0, sum_v} + (PROD_W + 1)'(cfg.process_noise);
  assign np_sat = (np > (PROD_W + 1)'(VAR_MAX)) ? VAR_MAX : np[VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= INITIAL_ESTIMATE_RST;
      p <= INITIAL_UNCERTAINTY_RST;
    end else begin
      case (cmd.op)
        DP_ACCEPT: begin
          if (meas.first_sample) begin
            x <= cfg.initial_estimate;
            p <= cfg.initial_uncertainty;
          end
        end
        DP_FIN: begin
          x <= est_new;
          p <= np_sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_ACCEPT: z <= meas.measurement;
      DP_LOAD: begin
        den      <= {1'b0, p} + {1'b0, cfg.measurement_noise};
        den_zero <= (p == '0) && (cfg.measurement_noise == '0);
        rem      <= {1'b0, p};
        quo      <= '0;
        neg      <= innov[MAG_W-1];
        mag      <= innov[MAG_W-1] ? MAG_W'(-innov) : MAG_W'(innov);
      end
      DP_DIV: begin
        quo <= {quo[GAIN_W-2:0], fits};
        rem <= fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      end
      DP_MUL_EL: prod <= PROD_W'(mul_a * mul_b);
      DP_MUL_EH: begin
        prod  <= PROD_W'(mul_a * mul_b);
        acc_e <= round_sum[PROD_W:GAIN_FRAC_BITS];
      end
      DP_MUL_VL: begin
        prod  <= PROD_W'(mul_a * mul_b);
        delta <= MAG_W'(PROD_W'(acc_e) + prod);
      end
      DP_MUL_VH: begin
        prod  <= PROD_W'(mul_a * mul_b);
        acc_v <= prod[PROD_W-1:GAIN_FRAC_BITS];
        if (nx > (MAG_W + 1)'(32'sh7fffffff)) begin
          est_new <= 32'sh7fffffff;
        end else if (nx < -(MAG_W + 1)'(33'sh080000000)) begin
          est_new <= 32'sh80000000;
        end else begin
          est_new <= nx[SAMPLE_W-1:0];
        end
      end
      DP_SUM: sum_v <= PROD_W'(acc_v) + prod;
      DP_FIN: begin
        res.estimate    <= est_new;
        res.gain        <= g_use;
        res.uncertainty <= np_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter.
//
//   channel | handshake              | beat
//   --------+------------------------+---------------------------------------
//   meas    | meas_valid, meas_stall | measurement, first_sample (meas_t)
//   res     | res_valid, res_stall   | estimate, gain, uncertainty (res_t)
//   cfg     | cfg_valid, cfg_ready   | cfg_index, cfg_data (48 bits)
//
// Each item passes through accept, operand load, the restoring divider for the
// gain (one quotient bit a cycle), four passes through the shared 25 x 24
// multiplier, one sum and a finish step that waits for a free result register.
// The next item is taken the cycle after its result is loaded into the result
// register, so a stalled result holds back the following item only at finish.
// Reset is synchronous; it restores the configuration registers and the filter state.
`timescale 1ns / 1ps
module scalar_kalman_filter_unit import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 meas_valid,
  output logic                 meas_stall,
  input  meas_t                meas,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAR_W-1:0]     cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  skf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .cmd        (cmd)
  );

  skf_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .meas (meas),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

// File: rtl/skf_checker.sv
// Port-level checks of the scalar Kalman filter, bound to the top level.
`timescale 1ns / 1ps
module skf_checker import skf_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  meas_valid,
  input logic  meas_stall,
  input logic  res_valid,
  input logic  res_stall,
  input res_t  res
);

  // A stalled result beat stays and keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Once a measurement is taken the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    meas_valid && !meas_stall |=> meas_stall)
    else $error("input not stalled after a measurement beat");

  // A new result only comes out of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(meas_stall))
    else $error("result appeared without an item in progress");

  // The gain never exceeds one.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.gain <= GAIN_ONE)
    else $error("gain above one");

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (.*);
